@@ design/urc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// urc_pkg: shared types and constants of the usage rate classifier
// Request and response structures, ring sizing, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package urc_pkg;

  // Ring sizing (legal range 2..64).
  localparam int RING_DEPTH = 6;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(RING_DEPTH);

  // Field widths.
  localparam int STAMP_W = 32;
  localparam int LEVEL_W = 14;
  localparam int WIN_W   = 24;
  localparam int CFG_W   = 24;
  localparam int PROD_W  = STAMP_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 14'd10000;
  localparam logic [15:0]        MS_PER_MIN = 16'd60000;

  // Response queue sizing.
  localparam int RSP_DEPTH = 8;
  localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DROP_LIMIT    = 3'd0,
    CFG_MIN_WINDOW    = 3'd1,
    CFG_THRESH_NORMAL = 3'd2,
    CFG_THRESH_ACTIVE = 3'd3,
    CFG_THRESH_HEAVY  = 3'd4
  } cfg_index_t;

  // Reset values.
  localparam logic [LEVEL_W-1:0] DROP_LIMIT_RST    = 14'd500;
  localparam logic [WIN_W-1:0]   MIN_WINDOW_RST    = 24'd240000;
  localparam logic [LEVEL_W-1:0] THRESH_NORMAL_RST = 14'd10;
  localparam logic [LEVEL_W-1:0] THRESH_ACTIVE_RST = 14'd20;
  localparam logic [LEVEL_W-1:0] THRESH_HEAVY_RST  = 14'd33;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp_ms;
    logic [LEVEL_W-1:0] usage_level;
  } in_req_t;

  typedef struct packed {
    logic [1:0] rate_class;
    logic       ring_emptied;
    logic       window_ready;
  } out_rsp_t;

  // One ring entry as stored in the sample memory.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LEVEL_W-1:0] level;
  } entry_t;

endpackage : urc_pkg
`default_nettype wire

@@ design/urc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// urc_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module urc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule : urc_ram
`default_nettype wire

@@ design/usage_rate_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// usage_rate_classifier: rate class of a usage-percent signal over a ring
// Each request carries a timestamp in ms and a usage level in hundredths of
// a percent. The block keeps the last samples in a ring memory and answers
// every request with one response: a rate class 0..3, a flag telling that a
// sharp drop emptied the ring, and a flag telling that the window is ready.
//
// Channels: the in_ and out_ channels use valid/ready; a request is taken at
// a clock edge with in_valid and in_ready high. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it.
//
// Pipeline: memory read, span/rise, products and compare, then the response
// queue. Throughput: one request per clock cycle while in_ready is high. The
// drop test and the ring pointer update complete in the accept cycle and the
// memory registers the oldest sample, so requests follow back to back.
//
// Stall: responses collect in an eight-entry queue. in_ready stays high as
// long as fewer than eight requests are accepted and not yet delivered, so
// a stalled receiver stops the input only after eight outstanding requests.
//
// Reset: synchronous, active low. The ring becomes empty and the registers
// take their defaults. The sample memory is not cleared; only entries written
// since the ring was last emptied are ever used.
// ----------------------------------------------------------------------------
module usage_rate_classifier (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire urc_pkg::in_req_t  in_data,
  // response channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output urc_pkg::out_rsp_t      out_data,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [urc_pkg::CFG_W-1:0] cfg_wdata
);
  import urc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEVEL_W-1:0] drop_limit_r;
  logic [WIN_W-1:0]   min_window_r;
  logic [LEVEL_W-1:0] thresh_normal_r;
  logic [LEVEL_W-1:0] thresh_active_r;
  logic [LEVEL_W-1:0] thresh_heavy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_limit_r    <= DROP_LIMIT_RST;
      min_window_r    <= MIN_WINDOW_RST;
      thresh_normal_r <= THRESH_NORMAL_RST;
      thresh_active_r <= THRESH_ACTIVE_RST;
      thresh_heavy_r  <= THRESH_HEAVY_RST;
    end else if (cfg_we) begin
      // Indexes past the last register are ignored.
      unique case (cfg_index)
        CFG_DROP_LIMIT:    drop_limit_r    <= cfg_wdata[LEVEL_W-1:0];
        CFG_MIN_WINDOW:    min_window_r    <= cfg_wdata[WIN_W-1:0];
        CFG_THRESH_NORMAL: thresh_normal_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_THRESH_ACTIVE: thresh_active_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_THRESH_HEAVY:  thresh_heavy_r  <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: clamp, drop test, ring pointer update, memory access
  // --------------------------------------------------------------------------
  logic                 in_fire;
  logic [FILL_W-1:0]    fill_r, fill_nxt, fill_base;
  logic [SLOT_W-1:0]    wslot_r, wslot_nxt, wr_slot, rd_slot;
  logic [LEVEL_W-1:0]   latest_level_r;
  logic [LEVEL_W-1:0]   level_clamped;
  logic                 drop;
  logic                 judge;
  entry_t               wr_entry, old_entry;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    level_clamped = (in_data.usage_level > LEVEL_MAX) ? LEVEL_MAX : in_data.usage_level;
    // Strict test: level + drop_limit < latest level, only with a nonempty ring.
    drop = (fill_r != '0) &&
           (({1'b0, level_clamped} + {1'b0, drop_limit_r}) < {1'b0, latest_level_r});
    wr_slot   = drop ? '0 : wslot_r;
    wslot_nxt = (wr_slot == LAST_SLOT) ? '0 : wr_slot + 1'b1;
    fill_base = drop ? '0 : fill_r;
    fill_nxt  = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 1'b1;
    judge     = (fill_nxt >= FILL_W'(2));
    // Writes restart at slot zero after reset or an emptied ring, so until the
    // ring is full the oldest sample sits in slot zero. Once full, the oldest
    // sample after this insert is the one following the slot being written.
    if (fill_r == FILL_FULL) begin
      rd_slot = (wslot_r == LAST_SLOT) ? '0 : wslot_r + 1'b1;
    end else begin
      rd_slot = '0;
    end
    wr_entry.stamp = in_data.stamp_ms;
    wr_entry.level = level_clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wslot_r <= '0;
    end else if (in_fire) begin
      fill_r  <= fill_nxt;
      wslot_r <= wslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      latest_level_r <= level_clamped;
    end
  end

  // The read of the oldest slot never hits the slot written in the same cycle
  // when a judgement is needed, and earlier writes are already visible.
  urc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RING_DEPTH),
    .ADDR_W(SLOT_W)
  ) u_ring (
    .clk    (clk),
    .we     (in_fire),
    .waddr  (wr_slot),
    .wdata  (wr_entry),
    .re     (in_fire),
    .raddr  (rd_slot),
    .rdata_r(old_entry)
  );

  // --------------------------------------------------------------------------
  // Stage 1: latest sample beside the oldest one from memory
  // --------------------------------------------------------------------------
  logic               s1_valid_r;
  logic               s1_judge_r;
  logic               s1_emptied_r;
  logic [STAMP_W-1:0] s1_stamp_r;
  logic [LEVEL_W-1:0] s1_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_judge_r   <= judge;
      s1_emptied_r <= drop;
      s1_stamp_r   <= in_data.stamp_ms;
      s1_level_r   <= level_clamped;
    end
  end

  logic [STAMP_W-1:0] span;
  logic [LEVEL_W-1:0] rise;
  logic               span_ok;

  always_comb begin
    span    = s1_stamp_r - old_entry.stamp;
    span_ok = (span != '0) && (span >= {{(STAMP_W-WIN_W){1'b0}}, min_window_r});
    rise    = (s1_level_r > old_entry.level) ? s1_level_r - old_entry.level : '0;
  end

  // --------------------------------------------------------------------------
  // Stage 2: span and rise registered
  // --------------------------------------------------------------------------
  logic               s2_valid_r;
  logic               s2_ready_r;
  logic               s2_emptied_r;
  logic [STAMP_W-1:0] s2_span_r;
  logic [LEVEL_W-1:0] s2_rise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_ready_r   <= s1_judge_r && span_ok;
      s2_emptied_r <= s1_emptied_r;
      s2_span_r    <= span;
      s2_rise_r    <= rise;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: rise * 60000 and each threshold times the span
  // --------------------------------------------------------------------------
  logic               s3_valid_r;
  logic               s3_ready_r;
  logic               s3_emptied_r;
  logic [PROD_W-1:0]  s3_lhs_r;
  logic [PROD_W-1:0]  s3_normal_r;
  logic [PROD_W-1:0]  s3_active_r;
  logic [PROD_W-1:0]  s3_heavy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_ready_r   <= s2_ready_r;
      s3_emptied_r <= s2_emptied_r;
      s3_lhs_r     <= PROD_W'(s2_rise_r) * PROD_W'(MS_PER_MIN);
      s3_normal_r  <= PROD_W'(thresh_normal_r) * PROD_W'(s2_span_r);
      s3_active_r  <= PROD_W'(thresh_active_r) * PROD_W'(s2_span_r);
      s3_heavy_r   <= PROD_W'(thresh_heavy_r) * PROD_W'(s2_span_r);
    end
  end

  // The first threshold not reached decides the class.
  out_rsp_t rsp;

  always_comb begin
    rsp.ring_emptied = s3_emptied_r;
    rsp.window_ready = s3_ready_r;
    if (!s3_ready_r) begin
      rsp.rate_class = 2'd0;
    end else if (s3_lhs_r < s3_normal_r) begin
      rsp.rate_class = 2'd0;
    end else if (s3_lhs_r < s3_active_r) begin
      rsp.rate_class = 2'd1;
    end else if (s3_lhs_r < s3_heavy_r) begin
      rsp.rate_class = 2'd2;
    end else begin
      rsp.rate_class = 2'd3;
    end
  end

  // --------------------------------------------------------------------------
  // Response queue and outstanding-request count
  // --------------------------------------------------------------------------
  out_rsp_t             rsp_q [RSP_DEPTH];
  logic [RSP_PTR_W:0]   rsp_wptr_r, rsp_rptr_r;
  logic [RSP_PTR_W:0]   pending_r;
  logic                 out_fire;

  assign out_fire  = out_valid && out_ready;
  assign out_valid = (rsp_wptr_r != rsp_rptr_r);
  assign out_data  = rsp_q[rsp_rptr_r[RSP_PTR_W-1:0]];
  // Every request in flight has a queue entry reserved, so the queue cannot
  // overflow and the pipeline never has to stall.
  assign in_ready  = (pending_r < (RSP_PTR_W+1)'(RSP_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_wptr_r <= '0;
      rsp_rptr_r <= '0;
      pending_r  <= '0;
    end else begin
      if (s3_valid_r) begin
        rsp_wptr_r <= rsp_wptr_r + 1'b1;
      end
      if (out_fire) begin
        rsp_rptr_r <= rsp_rptr_r + 1'b1;
      end
      if (in_fire && !out_fire) begin
        pending_r <= pending_r + 1'b1;
      end else if (!in_fire && out_fire) begin
        pending_r <= pending_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r) begin
      rsp_q[rsp_wptr_r[RSP_PTR_W-1:0]] <= rsp;
    end
  end

endmodule : usage_rate_classifier
`default_nettype wire
